// ----- sv/plid_pkg.sv -----
// Shared types and constants for the positional list block.
// Depends on nothing; imported by the cell and the top level.
package plid_pkg;

  localparam int DEPTH = 16;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMPW  = (CW > 8) ? CW : 8;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_DUMP   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOPOS = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    logic [IW-1:0] pos;
    logic [CW-1:0] count;
    logic [31:0] value;
  } cell_cmd_t;

endpackage

// ----- sv/plid_cell.sv -----
// One storage cell of the positional list chain.
// Depends on plid_pkg for the broadcast command type.
module plid_cell
  import plid_pkg::*;
(
  input  logic          clk,
  input  logic [IW-1:0] cell_idx,
  input  cell_cmd_t     cmd,
  input  logic [31:0]   left_word,
  input  logic [31:0]   right_word,
  input  logic [31:0]   head_word,
  output logic [31:0]   word
);

  logic [31:0]   word_r, word_nxt;
  logic [CW-1:0] idx_c, nxt_c, pos_c;

  assign idx_c = CW'(cell_idx);
  assign nxt_c = idx_c + CW'(1);
  assign pos_c = CW'(cmd.pos);

  always_comb begin
    word_nxt = word_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (idx_c == pos_c) word_nxt = cmd.value;
        else if (idx_c > pos_c && idx_c <= cmd.count) word_nxt = left_word;
      end
      CELL_DELETE: begin
        if (idx_c >= pos_c && nxt_c < cmd.count) word_nxt = right_word;
      end
      CELL_ROTATE: begin
        // close the ring at the last occupied cell
        if (nxt_c < cmd.count) word_nxt = right_word;
        else if (nxt_c == cmd.count) word_nxt = head_word;
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

// ----- sv/positional_list_insert_delete.sv -----
// Top level of the positional list: control, status and output register.
// Depends on plid_pkg and on plid_cell, one instance per list slot.
//
// Usage:
//   The input channel (in_valid/in_ready) takes one command item: mode,
//   position and value. The result channel (out_valid/out_ready) returns
//   status, entry, entry_valid, length and last for every result item.
//   Insert (mode 0) and delete (mode 1) shift the whole row of cells in
//   parallel in the accept cycle; their single result item shows up in the
//   cycle after acceptance, so they sustain one item per cycle while the
//   receiver keeps up.
//   Dump (mode 2) rotates the occupied cells one place per cycle past the
//   head cell and emits the head each cycle while the receiver keeps up:
//   n result items for n entries (one empty item for an empty list), last
//   set on the final one. The rotation ends with the list back in its
//   original order. Input is held off during a dump.
//   Mode 3 answers one ok item and changes nothing.
//   Reset (rst_n low, synchronous) empties the list and drops any pending
//   result; cell contents are not cleared, only the count.
//   When the receiver stalls, the output register holds its item and the
//   block stops accepting input and stops rotating until it is taken.
module positional_list_insert_delete
  import plid_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_mode,
  input  logic signed [7:0] in_position,
  input  logic signed [31:0] in_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic signed [31:0] out_entry,
  output logic              out_entry_valid,
  output logic [4:0]        out_length,
  output logic              out_last
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] dump_idx_r, dump_idx_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [31:0]   out_entry_r, out_entry_nxt;
  logic          out_entry_valid_r, out_entry_valid_nxt;
  logic [CW-1:0] out_length_r, out_length_nxt;
  logic          out_last_r, out_last_nxt;

  logic          slot_free, in_fire;
  logic          pos_nonneg, list_full, ins_ok, del_ok, dump_last;
  logic [CMPW-1:0] pos_mag, cnt_ext;
  cell_cmd_t     cmd;
  logic [31:0]   cell_word [DEPTH];

  // output slot is free when empty or being drained this cycle
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign in_fire   = in_valid && in_ready;

  assign pos_nonneg = !in_position[7];
  assign pos_mag    = CMPW'(in_position[6:0]);
  assign cnt_ext    = CMPW'(count_r);
  assign list_full  = (count_r == CW'(DEPTH));
  assign ins_ok     = pos_nonneg && (pos_mag <= cnt_ext);
  assign del_ok     = pos_nonneg && (pos_mag != '0) && (pos_mag <= cnt_ext);
  assign dump_last  = (CW'(dump_idx_r) + CW'(1)) == count_r;

  always_comb begin
    state_nxt           = state_r;
    count_nxt           = count_r;
    dump_idx_nxt        = dump_idx_r;
    out_valid_nxt       = out_valid_r && !out_ready;
    out_status_nxt      = out_status_r;
    out_entry_nxt       = out_entry_r;
    out_entry_valid_nxt = out_entry_valid_r;
    out_length_nxt      = out_length_r;
    out_last_nxt        = out_last_r;
    cmd.op              = CELL_HOLD;
    cmd.pos             = '0;
    cmd.count           = count_r;
    cmd.value           = in_value;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_valid_nxt       = 1'b1;
          out_status_nxt      = ST_OK;
          out_entry_nxt       = '0;
          out_entry_valid_nxt = 1'b0;
          out_length_nxt      = count_r;
          out_last_nxt        = 1'b1;
          case (in_mode)
            MODE_INSERT: begin
              if (!ins_ok) begin
                out_status_nxt = ST_NOPOS;
              end else if (list_full) begin
                out_status_nxt = ST_FULL;
              end else begin
                cmd.op         = CELL_INSERT;
                cmd.pos        = IW'(pos_mag);
                count_nxt      = count_r + CW'(1);
                out_length_nxt = count_nxt;
              end
            end
            MODE_DELETE: begin
              if (!del_ok) begin
                out_status_nxt = ST_NOPOS;
              end else begin
                cmd.op         = CELL_DELETE;
                cmd.pos        = IW'(pos_mag - CMPW'(1));
                count_nxt      = count_r - CW'(1);
                out_length_nxt = count_nxt;
              end
            end
            MODE_DUMP: begin
              // empty list answers the single default item; else stream
              if (count_r != '0) begin
                out_valid_nxt = 1'b0;
                dump_idx_nxt  = '0;
                state_nxt     = S_DUMP;
              end
            end
            default: ;
          endcase
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          // emit the head, then rotate the ring one place
          cmd.op              = CELL_ROTATE;
          out_valid_nxt       = 1'b1;
          out_status_nxt      = ST_OK;
          out_entry_nxt       = cell_word[0];
          out_entry_valid_nxt = 1'b1;
          out_length_nxt      = count_r;
          out_last_nxt        = dump_last;
          if (dump_last) begin
            state_nxt    = S_IDLE;
            dump_idx_nxt = '0;
          end else begin
            dump_idx_nxt = dump_idx_r + IW'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [31:0] left_w, right_w;
      if (gi == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = cell_word[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_mid_r
        assign right_w = cell_word[gi+1];
      end
      plid_cell u_cell (
        .clk        (clk),
        .cell_idx   (IW'(gi)),
        .cmd        (cmd),
        .left_word  (left_w),
        .right_word (right_w),
        .head_word  (cell_word[0]),
        .word       (cell_word[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dump_idx_r  <= dump_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r      <= out_status_nxt;
    out_entry_r       <= out_entry_nxt;
    out_entry_valid_r <= out_entry_valid_nxt;
    out_length_r      <= out_length_nxt;
    out_last_r        <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry       = out_entry_r;
  assign out_entry_valid = out_entry_valid_r;
  assign out_length      = 5'(out_length_r);
  assign out_last        = out_last_r;

  // count never exceeds the number of cells
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  // a dump only runs over a non-empty list and never past its end
  a_dump_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> (count_r != '0) && (CW'(dump_idx_r) < count_r))
    else $error("dump index out of range");

  // a good insert grows the list by one
  a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_mode == MODE_INSERT && ins_ok && !list_full)
      |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not grow the list");

  // count holds during a dump
  a_dump_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |=> $stable(count_r))
    else $error("count changed during dump");

endmodule
